@@ sv/tnmb_pkg.sv @@
// shared types and constants for the timestamp nearest match buffer
`default_nettype none
package tnmb_pkg;

  localparam int STAMP_W     = 48;
  localparam int ANGLE_W     = 32;
  localparam int MAXC_W      = 11;
  localparam int DEF_DEPTH   = 1024;

  localparam logic [STAMP_W-1:0] WINDOW_RESET = 48'd1000000;
  localparam logic [MAXC_W-1:0]  MAXC_RESET   = 11'd1000;

  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_MAXCNT = 1'b1;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [ANGLE_W-1:0] angle;
  } entry_t;

endpackage
`default_nettype wire

@@ sv/timestamp_nearest_match_buffer_core.sv @@
// top level: sorted timestamp table with nearest match lookup
// insert: busy for the binary search and for the one-entry-per-cycle shift of the
//   entries above the insert position through the memory ports
// lookup: result follows the binary search; an empty table answers in the cycle after start
//   without raising busy; one transaction at a time, busy stays high until it completes
// synchronous active-low reset empties the table and restores register defaults
`default_nettype none
module timestamp_nearest_match_buffer_core
  import tnmb_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_command,
  input  wire logic [STAMP_W-1:0] in_time_stamp,
  input  wire logic [ANGLE_W-1:0] in_angle_value,
  output logic                    out_valid,
  output logic                    out_found,
  output logic [STAMP_W-1:0]      out_time_error,
  output logic [ANGLE_W-1:0]      out_matched_angle,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [STAMP_W-1:0] cfg_data
);

  localparam int MEM_DEPTH = TABLE_DEPTH + 1;
  localparam int IDX_W     = $clog2(MEM_DEPTH);
  localparam int CNT_W     = $clog2(TABLE_DEPTH + 2);
  localparam logic [IDX_W:0] MEM_DEPTH_C = (IDX_W + 1)'(MEM_DEPTH);
  localparam logic [IDX_W-1:0] HEAD_LAST = IDX_W'(MEM_DEPTH - 1);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_SRD   = 13'b0000000000010,
    ST_SCMP  = 13'b0000000000100,
    ST_IDUP  = 13'b0000000001000,
    ST_ISH   = 13'b0000000010000,
    ST_IWR   = 13'b0000000100000,
    ST_SP0   = 13'b0000001000000,
    ST_SP1   = 13'b0000010000000,
    ST_SPCMP = 13'b0000100000000,
    ST_LIM   = 13'b0001000000000,
    ST_LKA   = 13'b0010000000000,
    ST_LKB   = 13'b0100000000000,
    ST_LKOUT = 13'b1000000000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [STAMP_W-1:0]   window_r;
  logic [MAXC_W-1:0]    maxc_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [IDX_W-1:0]     src_r, src_nxt, wdst_r, wdst_nxt;
  logic                 more_r, more_nxt, pend_r, pend_nxt;
  logic                 cmd_r;
  logic [STAMP_W-1:0]   key_r;
  logic [ANGLE_W-1:0]   ang_r;
  logic [STAMP_W-1:0]   old_r, old_nxt;
  entry_t               sel_r, sel_nxt;
  logic                 ov_r, ov_nxt, of_r, of_nxt;
  logic [STAMP_W-1:0]   oerr_r, oerr_nxt;
  logic [ANGLE_W-1:0]   oang_r, oang_nxt;

  logic [IDX_W-1:0]     ra_idx, wa_idx, ra_phys, wa_phys;
  logic                 we;
  entry_t               wdata, rd;
  logic [CNT_W:0]       mid_sum;
  logic [STAMP_W-1:0]   span;
  logic [31:0]          limit;
  logic                 accept;

  function automatic logic [IDX_W-1:0] to_phys(input logic [IDX_W-1:0] hd,
                                                input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] s;
    s = {1'b0, hd} + {1'b0, idx};
    if (s >= MEM_DEPTH_C) begin
      s = s - MEM_DEPTH_C;
    end
    return s[IDX_W-1:0];
  endfunction

  assign ra_phys = to_phys(head_r, ra_idx);
  assign wa_phys = to_phys(head_r, wa_idx);

  tnmb_ram #(.DEPTH(MEM_DEPTH), .AW(IDX_W)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wa_phys),
    .wdata (wdata),
    .raddr (ra_phys),
    .rdata (rd)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid         = ov_r;
  assign out_found         = of_r;
  assign out_time_error    = oerr_r;
  assign out_matched_angle = oang_r;

  assign mid_sum = ({1'b0, lo_r} + {1'b0, hi_r}) >> 1;
  assign span    = rd.stamp - old_r;
  assign limit   = (32'(maxc_r) < 32'(TABLE_DEPTH)) ? 32'(maxc_r) : 32'(TABLE_DEPTH);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    head_nxt  = head_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    src_nxt   = src_r;
    wdst_nxt  = wdst_r;
    more_nxt  = more_r;
    pend_nxt  = pend_r;
    old_nxt   = old_r;
    sel_nxt   = sel_r;
    ov_nxt    = 1'b0;
    of_nxt    = of_r;
    oerr_nxt  = oerr_r;
    oang_nxt  = oang_r;
    ra_idx    = '0;
    wa_idx    = '0;
    we        = 1'b0;
    wdata     = rd;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_LOOKUP && count_r == '0) begin
            ov_nxt   = 1'b1;
            of_nxt   = 1'b0;
            oerr_nxt = '0;
            oang_nxt = '0;
          end else begin
            lo_nxt    = '0;
            hi_nxt    = count_r;
            state_nxt = ST_SRD;
          end
        end
      end
      ST_SRD: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_sum[CNT_W-1:0];
          ra_idx    = mid_sum[IDX_W-1:0];
          state_nxt = ST_SCMP;
        end else if (cmd_r == CMD_INSERT) begin
          if (lo_r < count_r) begin
            ra_idx    = lo_r[IDX_W-1:0];
            state_nxt = ST_IDUP;
          end else begin
            state_nxt = ST_IWR;
          end
        end else begin
          ra_idx    = (lo_r < count_r) ? lo_r[IDX_W-1:0] : IDX_W'(count_r - 1'b1);
          state_nxt = ST_LKA;
        end
      end
      ST_SCMP: begin
        if (rd.stamp < key_r) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = ST_SRD;
      end
      ST_IDUP: begin
        if (rd.stamp == key_r) begin
          state_nxt = ST_IDLE;
        end else begin
          src_nxt   = IDX_W'(count_r - 1'b1);
          more_nxt  = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = ST_ISH;
        end
      end
      ST_ISH: begin
        if (pend_r) begin
          we     = 1'b1;
          wa_idx = wdst_r;
          wdata  = rd;
        end
        if (more_r) begin
          ra_idx   = src_r;
          wdst_nxt = src_r + 1'b1;
          pend_nxt = 1'b1;
          if (src_r == lo_r[IDX_W-1:0]) begin
            more_nxt = 1'b0;
          end else begin
            src_nxt = src_r - 1'b1;
          end
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_IWR;
        end
      end
      ST_IWR: begin
        we        = 1'b1;
        wa_idx    = lo_r[IDX_W-1:0];
        wdata     = '{stamp: key_r, angle: ang_r};
        count_nxt = count_r + 1'b1;
        state_nxt = (count_r >= CNT_W'(2)) ? ST_SP0 : ST_IDLE;
      end
      ST_SP0: begin
        ra_idx    = '0;
        state_nxt = ST_SP1;
      end
      ST_SP1: begin
        old_nxt   = rd.stamp;
        ra_idx    = IDX_W'(count_r - 1'b1);
        state_nxt = ST_SPCMP;
      end
      ST_SPCMP: begin
        if ({1'b0, span} > {window_r, 1'b0}) begin
          count_nxt = '0;
        end else if (span > window_r) begin
          count_nxt = count_r - 1'b1;
          head_nxt  = (head_r == HEAD_LAST) ? '0 : head_r + 1'b1;
        end
        state_nxt = ST_LIM;
      end
      ST_LIM: begin
        if (32'(count_r) > limit) begin
          count_nxt = count_r - 1'b1;
          head_nxt  = (head_r == HEAD_LAST) ? '0 : head_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_LKA: begin
        sel_nxt = rd;
        if (lo_r != '0 && lo_r < count_r) begin
          ra_idx    = IDX_W'(lo_r - 1'b1);
          state_nxt = ST_LKB;
        end else begin
          state_nxt = ST_LKOUT;
        end
      end
      ST_LKB: begin
        if ((key_r - rd.stamp) < (sel_r.stamp - key_r)) begin
          sel_nxt = rd;
        end
        state_nxt = ST_LKOUT;
      end
      ST_LKOUT: begin
        ov_nxt    = 1'b1;
        of_nxt    = 1'b1;
        oerr_nxt  = (sel_r.stamp >= key_r) ? sel_r.stamp - key_r : key_r - sel_r.stamp;
        oang_nxt  = sel_r.angle;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      head_r   <= '0;
      ov_r     <= 1'b0;
      more_r   <= 1'b0;
      pend_r   <= 1'b0;
      window_r <= WINDOW_RESET;
      maxc_r   <= MAXC_RESET;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      ov_r    <= ov_nxt;
      more_r  <= more_nxt;
      pend_r  <= pend_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW: window_r <= cfg_data;
          REG_MAXCNT: maxc_r   <= cfg_data[MAXC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    src_r  <= src_nxt;
    wdst_r <= wdst_nxt;
    old_r  <= old_nxt;
    sel_r  <= sel_nxt;
    of_r   <= of_nxt;
    oerr_r <= oerr_nxt;
    oang_r <= oang_nxt;
    if (accept) begin
      cmd_r <= in_command;
      key_r <= in_time_stamp;
      ang_r <= in_angle_value;
    end
  end

endmodule
`default_nettype wire

@@ sv/tnmb_ram.sv @@
// entry memory, one write port and one registered read port
`default_nettype none
module tnmb_ram
  import tnmb_pkg::*;
#(
  parameter int DEPTH = DEF_DEPTH + 1,
  parameter int AW    = $clog2(DEF_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/tnmb_checker.sv @@
// port-level checks for the timestamp nearest match buffer, bound to the top level
`default_nettype none
module tnmb_checker
  import tnmb_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               in_command,
  input wire logic               out_valid,
  input wire logic               out_found,
  input wire logic [STAMP_W-1:0] out_time_error,
  input wire logic [ANGLE_W-1:0] out_matched_angle,
  input wire logic               cfg_ready
);

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_time_error == '0 && out_matched_angle == '0)
    else $error("miss result not zero");

  a_insert_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command == CMD_INSERT |=> !out_valid)
    else $error("insert produced a result");

  a_lookup_pending: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command == CMD_LOOKUP |=> out_valid || busy)
    else $error("lookup dropped");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> cfg_ready)
    else $error("config port blocked");

endmodule

bind timestamp_nearest_match_buffer_core tnmb_checker u_tnmb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_command        (in_command),
  .out_valid         (out_valid),
  .out_found         (out_found),
  .out_time_error    (out_time_error),
  .out_matched_angle (out_matched_angle),
  .cfg_ready         (cfg_ready)
);
`default_nettype wire

@@ sim/timestamp_nearest_match_buffer_core_test.sv @@
// self-checking testbench for the timestamp nearest match buffer core
`timescale 1ns / 1ps
module timestamp_nearest_match_buffer_core_test;
  import tnmb_pkg::*;

  localparam int DEPTH       = DEF_DEPTH;
  localparam int SETTLE      = 1200;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic               command;
    logic [STAMP_W-1:0] stamp;
    logic [ANGLE_W-1:0] angle;
  } request_t;

  typedef struct {
    logic               found;
    logic [STAMP_W-1:0] error;
    logic [ANGLE_W-1:0] angle;
  } match_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               in_command = CMD_INSERT;
  logic [STAMP_W-1:0] in_time_stamp = '0;
  logic [ANGLE_W-1:0] in_angle_value = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_index = REG_WINDOW;
  logic [STAMP_W-1:0] cfg_data = '0;
  logic               busy, out_valid, out_found, cfg_ready;
  logic [STAMP_W-1:0] out_time_error;
  logic [ANGLE_W-1:0] out_matched_angle;

  request_t pending_requests[$];
  match_t   expected_matches[$];
  request_t active_request;
  int       gap_left = 0;
  int       mismatches = 0;
  int       cycles = 0;

  logic [STAMP_W-1:0] table_stamp[0:DEPTH];
  logic [ANGLE_W-1:0] table_angle[0:DEPTH];
  int                 table_count = 0;
  logic [STAMP_W-1:0] window_len = WINDOW_RESET;
  logic [MAXC_W-1:0]  count_limit = MAXC_RESET;
  logic [STAMP_W-1:0] last_stamp = '0;

  timestamp_nearest_match_buffer_core i_dut (
    .clk, .rst_n, .start, .busy, .in_command, .in_time_stamp, .in_angle_value,
    .out_valid, .out_found, .out_time_error, .out_matched_angle,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #10 clk = ~clk;

  function automatic int first_at_or_above(logic [STAMP_W-1:0] key);
    int lo, hi, mid;
    lo = 0;
    hi = table_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (table_stamp[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic void drop_oldest_entry();
    if (table_count == 0) return;
    for (int i = 0; i < table_count - 1; i++) begin
      table_stamp[i] = table_stamp[i+1];
      table_angle[i] = table_angle[i+1];
    end
    table_count--;
  endfunction

  function automatic void store_measurement(request_t r);
    int pos, limit;
    logic [63:0] span;
    pos = first_at_or_above(r.stamp);
    if (pos < table_count && table_stamp[pos] == r.stamp) return;
    for (int i = table_count; i > pos; i--) begin
      table_stamp[i] = table_stamp[i-1];
      table_angle[i] = table_angle[i-1];
    end
    table_stamp[pos] = r.stamp;
    table_angle[pos] = r.angle;
    table_count++;
    if (table_count <= 2) return;
    span = 64'(table_stamp[table_count-1]) - 64'(table_stamp[0]);
    if (span > 2 * 64'(window_len)) table_count = 0;
    else if (span > 64'(window_len)) drop_oldest_entry();
    limit = (int'(count_limit) < DEPTH) ? int'(count_limit) : DEPTH;
    if (table_count > limit) drop_oldest_entry();
  endfunction

  function automatic match_t nearest_match(logic [STAMP_W-1:0] key);
    match_t m;
    int lo, pick;
    m = '{1'b0, '0, '0};
    if (table_count == 0) return m;
    lo = first_at_or_above(key);
    if (lo >= table_count) pick = table_count - 1;
    else if (lo == 0) pick = 0;
    else if (key - table_stamp[lo-1] < table_stamp[lo] - key) pick = lo - 1;
    else pick = lo;
    m.found = 1'b1;
    m.error = (table_stamp[pick] >= key) ? table_stamp[pick] - key : key - table_stamp[pick];
    m.angle = table_angle[pick];
    return m;
  endfunction

  // driver: one transaction at a time with a random gap after each
  always @(posedge clk) begin : driver_proc
    logic next_start;
    next_start = start;
    if (rst_n) begin
      if (start && !busy) begin
        if (active_request.command == CMD_LOOKUP)
          expected_matches.push_back(nearest_match(active_request.stamp));
        else
          store_measurement(active_request);
        next_start = 1'b0;
        gap_left = $urandom_range(0, 3);
      end
      if (!next_start) begin
        if (gap_left > 0) gap_left--;
        else if (pending_requests.size() > 0) begin
          active_request = pending_requests.pop_front();
          in_command     <= active_request.command;
          in_time_stamp  <= active_request.stamp;
          in_angle_value <= active_request.angle;
          next_start = 1'b1;
        end
      end
    end
    start <= next_start;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction at cycle %0d", cycles);
      end else begin
        match_t e;
        e = expected_matches.pop_front();
        if (out_found !== e.found || out_time_error !== e.error
            || out_matched_angle !== e.angle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected found %0b err %0d angle %h, got %0b %0d %h",
                     e.found, e.error, e.angle, out_found, out_time_error, out_matched_angle);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_request(logic cmd, logic [STAMP_W-1:0] ts, logic [ANGLE_W-1:0] ang);
    request_t r;
    r.command = cmd;
    r.stamp   = ts;
    r.angle   = ang;
    pending_requests.push_back(r);
  endtask

  task automatic drain();
    while (pending_requests.size() > 0 || start || expected_matches.size() > 0 || busy)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [STAMP_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_WINDOW) window_len = value;
    else count_limit = value[MAXC_W-1:0];
  endtask

  function automatic logic [STAMP_W-1:0] rand_stamp();
    return STAMP_W'({$urandom, $urandom});
  endfunction

  task automatic random_phase(int n, logic [STAMP_W-1:0] reach);
    logic [STAMP_W-1:0] base, ts;
    base = rand_stamp();
    for (int i = 0; i < n; i++) begin
      ts = base + ((reach == '1) ? rand_stamp() : rand_stamp() % (reach + 1));
      if ($urandom_range(0, 9) == 0) ts = last_stamp;
      else if ($urandom_range(0, 19) == 0) ts = rand_stamp();
      if ($urandom_range(0, 9) < 6) begin
        push_request(CMD_INSERT, ts, $urandom);
        last_stamp = ts;
      end else begin
        push_request(CMD_LOOKUP, ts, $urandom);
      end
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    push_request(CMD_LOOKUP, 48'd5, 32'h1234_5678);
    push_request(CMD_INSERT, 48'd100, 32'h7FFF_FFFF);
    push_request(CMD_INSERT, 48'd200, 32'h8000_0000);
    push_request(CMD_INSERT, 48'd100, 32'h0000_0001);
    push_request(CMD_LOOKUP, 48'd150, '0);
    push_request(CMD_LOOKUP, 48'd149, '1);
    push_request(CMD_LOOKUP, 48'd0, '0);
    push_request(CMD_LOOKUP, '1, '0);
    push_request(CMD_INSERT, 48'd1500000, 32'hFFFF_FFFF);
    push_request(CMD_LOOKUP, 48'd300, '0);
    push_request(CMD_INSERT, 48'd0, 32'h0000_0000);
    push_request(CMD_INSERT, '1, 32'h5A5A_A5A5);
    push_request(CMD_LOOKUP, 48'd1, '0);
    push_request(CMD_INSERT, '1, 32'h1111_1111);
    push_request(CMD_INSERT, 48'hFFFF_FFFF_FFF0, 32'h2222_2222);
    push_request(CMD_INSERT, 48'hFFFF_FFFF_FFF8, 32'h3333_3333);
    push_request(CMD_LOOKUP, 48'hFFFF_FFFF_FFF4, '0);
    push_request(CMD_LOOKUP, '1, '0);
    drain();

    random_phase(90, 48'd3000000);

    write_register(REG_WINDOW, 48'd50);
    write_register(REG_MAXCNT, 48'd3);
    random_phase(90, 48'd160);

    write_register(REG_WINDOW, '1);
    write_register(REG_MAXCNT, 48'd1024);
    random_phase(90, '1);

    write_register(REG_WINDOW, '0);
    write_register(REG_MAXCNT, 48'hFFFF_FFFF_F7FF);
    random_phase(90, 48'd2);

    write_register(REG_WINDOW, 48'd1000);
    write_register(REG_MAXCNT, 48'd0);
    random_phase(90, 48'd2500);

    write_register(REG_WINDOW, 48'hAAAA_5555_AAAA);
    write_register(REG_MAXCNT, 48'd20);
    random_phase(90, 48'hFFFF_FFFF);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/tnmb_pkg.sv
sv/tnmb_ram.sv
sv/timestamp_nearest_match_buffer_core.sv
sv/tnmb_checker.sv
sim/timestamp_nearest_match_buffer_core_test.sv
